// File: rtl/mvd_pkg.sv
// ----------------------------------------------------------------------------
// mvd_pkg
// Shared types and constants for the mode-vote downscaler with run-length
// output.
// ----------------------------------------------------------------------------
package mvd_pkg;

	localparam int PIX_W      = 8;
	localparam int CLS_W      = 5;
	localparam int RUN_W      = 19;
	localparam int SIDE_W     = 11;
	localparam int MIN_W      = 10;
	localparam int CFG_DATA_W = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int Q_DEPTH    = 4;

	localparam logic [RUN_W-1:0] RUN_MAX  = '1;
	localparam logic [RUN_W-1:0] RUN_ONE  = RUN_W'(1);
	localparam int               SIDE_MIN = 2;

	// value / 10 for 8-bit values: (v * 205) >> 11
	localparam logic [2*PIX_W-1:0] DIV10_MUL = (2*PIX_W)'(205);
	localparam int                 DIV10_SH  = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_COMPRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIDE = 2'd3;

	localparam logic [SIDE_W-1:0] WIDTH_RST    = 11'd64;
	localparam logic [SIDE_W-1:0] HEIGHT_RST   = 11'd64;
	localparam logic [MIN_W-1:0]  MIN_SIDE_RST = 10'd20;

	// one queued job for the back end
	typedef struct packed {
		logic             rej;
		logic             last;
		logic [PIX_W-1:0] value;
		logic [CLS_W-1:0] cls;
	} mvd_cmd_t;

	typedef struct packed {
		logic [PIX_W-1:0] value;
		logic [RUN_W-1:0] len;
		logic             eof;
		logic             rej;
	} mvd_res_t;

endpackage

// File: rtl/mvd_ram.sv
// ----------------------------------------------------------------------------
// mvd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mvd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/mvd_front.sv
// ----------------------------------------------------------------------------
// mvd_front
// Raster counters, top row store, 2x2 class vote; queues one job per
// finished block and one per rejected frame.
// ----------------------------------------------------------------------------
module mvd_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pixel_valid,
	output logic                        pixel_stall,
	input  logic [mvd_pkg::PIX_W-1:0]   pixel,
	input  logic [mvd_pkg::SIDE_W-1:0]  image_width,
	input  logic [mvd_pkg::SIDE_W-1:0]  image_height,
	input  logic [mvd_pkg::MIN_W-1:0]   min_side,
	input  logic                        q_full,
	output logic                        q_push,
	output mvd_pkg::mvd_cmd_t           q_data
);

	import mvd_pkg::*;

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int HD   = (MAX_WIDTH + 1) / 2;
	localparam int MAXS = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int SWM  = $clog2(MAXS + 1);
	localparam int SW   = (SWM > SIDE_W) ? SWM : SIDE_W;

	function automatic logic [CLS_W-1:0] div10(input logic [PIX_W-1:0] p);
		logic [2*PIX_W-1:0] m;
		m = (2*PIX_W)'(p) * DIV10_MUL;
		return CLS_W'(m >> DIV10_SH);
	endfunction

	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic [PIX_W-1:0] left_q;

	logic             s1_valid_q;
	logic             s1_rej_q;
	logic             s1_last_q;
	logic [PIX_W-1:0] s1_px_q;
	logic [PIX_W-1:0] s1_left_q;

	logic [SW-1:0] iw, ih, w_e, h_e, we_e, he_e, col_x, row_x, min_x;
	logic          col_wrap, row_wrap, reject, in_block, last_block;
	logic          acc, wr_even, wr_odd, do_vote, do_rej, cmd_acc;
	logic [PIX_W-1:0] ra, rb;

	assign iw    = SW'(image_width);
	assign ih    = SW'(image_height);
	assign min_x = SW'(min_side);
	assign w_e   = (iw < SW'(SIDE_MIN)) ? SW'(SIDE_MIN) :
	               (iw > SW'(MAX_WIDTH)) ? SW'(MAX_WIDTH) : iw;
	assign h_e   = (ih < SW'(SIDE_MIN)) ? SW'(SIDE_MIN) :
	               (ih > SW'(MAX_HEIGHT)) ? SW'(MAX_HEIGHT) : ih;
	assign we_e  = {w_e[SW-1:1], 1'b0};
	assign he_e  = {h_e[SW-1:1], 1'b0};
	assign col_x = SW'(col_q);
	assign row_x = SW'(row_q);

	assign col_wrap   = (col_x + SW'(1)) >= w_e;
	assign row_wrap   = (row_x + SW'(1)) >= h_e;
	assign reject     = (w_e <= min_x) || (h_e <= min_x);
	assign in_block   = (col_x < we_e) && (row_x < he_e);
	assign last_block = (col_x == we_e - SW'(1)) && (row_x == he_e - SW'(1));

	assign pixel_stall = s1_valid_q && q_full;
	assign acc         = pixel_valid && !pixel_stall;
	assign wr_even     = acc && !row_q[0] && !col_q[0];
	assign wr_odd      = acc && !row_q[0] && col_q[0];
	assign do_vote     = acc && row_q[0] && col_q[0] && !reject && in_block;
	assign do_rej      = acc && reject && col_wrap && row_wrap;
	assign cmd_acc     = do_vote || do_rej;
	assign q_push      = s1_valid_q && !q_full;

	mvd_ram #(.WIDTH(PIX_W), .DEPTH(HD)) u_ram_even (
		.clk   (clk),
		.we    (wr_even),
		.waddr (col_q[CW-1:1]),
		.wdata (pixel),
		.re    (do_vote),
		.raddr (col_q[CW-1:1]),
		.rdata (ra)
	);

	mvd_ram #(.WIDTH(PIX_W), .DEPTH(HD)) u_ram_odd (
		.clk   (clk),
		.we    (wr_odd),
		.waddr (col_q[CW-1:1]),
		.wdata (pixel),
		.re    (do_vote),
		.raddr (col_q[CW-1:1]),
		.rdata (rb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			left_q     <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_wrap ? '0 : row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
				if (row_q[0] && !col_q[0]) begin
					left_q <= pixel;
				end
			end
			if (cmd_acc) begin
				s1_valid_q <= 1'b1;
			end else if (q_push) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			s1_rej_q  <= do_rej;
			s1_last_q <= last_block;
			s1_px_q   <= pixel;
			s1_left_q <= left_q;
		end
	end

	// fixed-priority vote over the four classes
	always_comb begin
		logic [CLS_W-1:0] ca, cb, cc, cd;
		logic ab, ac, ad, bc, bd, cdq;
		ca  = div10(ra);
		cb  = div10(rb);
		cc  = div10(s1_left_q);
		cd  = div10(s1_px_q);
		ab  = ca == cb;
		ac  = ca == cc;
		ad  = ca == cd;
		bc  = cb == cc;
		bd  = cb == cd;
		cdq = cc == cd;
		q_data.rej   = s1_rej_q;
		q_data.last  = s1_last_q;
		q_data.value = ra;
		q_data.cls   = ca;
		if (ab && bc && cdq) begin
			q_data.value = ra;
			q_data.cls   = ca;
		end else if (bc && cdq) begin
			q_data.value = rb;
			q_data.cls   = cb;
		end else if (cdq && ad) begin
			q_data.value = s1_left_q;
			q_data.cls   = cc;
		end else if (bd && ad) begin
			q_data.value = rb;
			q_data.cls   = cb;
		end else if (ab && bc) begin
			q_data.value = ra;
			q_data.cls   = ca;
		end else if ((ab && !cdq) || (ac && !bd) || (ad && !bc)) begin
			q_data.value = ra;
			q_data.cls   = ca;
		end else if ((bc && !ad) || (bd && !ac)) begin
			q_data.value = rb;
			q_data.cls   = cb;
		end else if (cdq && !ab) begin
			q_data.value = s1_left_q;
			q_data.cls   = cc;
		end
	end

endmodule

// File: rtl/mvd_fifo.sv
// ----------------------------------------------------------------------------
// mvd_fifo
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
module mvd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mvd_pkg::mvd_cmd_t wdata,
	output logic              full,
	input  logic              pop,
	output mvd_pkg::mvd_cmd_t rdata,
	output logic              empty
);

	import mvd_pkg::*;

	localparam int PW = $clog2(Q_DEPTH);
	localparam int NW = $clog2(Q_DEPTH + 1);

	mvd_cmd_t        mem_q [Q_DEPTH];
	logic [PW-1:0]   wp_q, rp_q;
	logic [NW-1:0]   cnt_q;

	assign full  = cnt_q == NW'(Q_DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + PW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + NW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && empty))
		else $error("queue overrun or underrun");

endmodule

// File: rtl/mvd_back.sv
// ----------------------------------------------------------------------------
// mvd_back
// Run tracker and result register; a second result of a job waits in a
// holding register.
// ----------------------------------------------------------------------------
module mvd_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       compress_mode,
	input  logic                       q_empty,
	input  mvd_pkg::mvd_cmd_t          q_data,
	output logic                       q_pop,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [mvd_pkg::PIX_W-1:0]  value,
	output logic [mvd_pkg::RUN_W-1:0]  run_length,
	output logic                       end_of_frame,
	output logic                       rejected
);

	import mvd_pkg::*;

	logic             out_valid_q, pend_valid_q;
	mvd_res_t         out_q, pend_q;
	logic             run_open_q;
	logic [CLS_W-1:0] run_class_q;
	logic [RUN_W-1:0] run_count_q;

	logic             take, out_free;
	logic [1:0]       n;
	mvd_res_t         r0, r1, fl;
	logic             nx_open;
	logic [CLS_W-1:0] nx_class;
	logic [RUN_W-1:0] nx_count;

	assign take     = out_valid_q && !result_stall;
	assign out_free = !out_valid_q || take;
	assign q_pop    = !q_empty && !pend_valid_q && out_free;

	always_comb begin
		n        = 2'd0;
		r0       = '0;
		r1       = '0;
		fl       = '0;
		nx_open  = run_open_q;
		nx_class = run_class_q;
		nx_count = run_count_q;
		if (q_data.rej) begin
			r0       = '{value: '0, len: '0, eof: 1'b1, rej: 1'b1};
			n        = 2'd1;
			nx_open  = 1'b0;
			nx_class = '0;
			nx_count = '0;
		end else if (!compress_mode) begin
			r0 = '{value: q_data.value, len: RUN_ONE, eof: q_data.last, rej: 1'b0};
			n  = 2'd1;
			if (q_data.last) begin
				nx_open = 1'b0;
			end
		end else begin
			if (run_open_q && q_data.cls == run_class_q) begin
				if (run_count_q < RUN_MAX) begin
					nx_count = run_count_q + RUN_ONE;
				end
			end else begin
				if (run_open_q) begin
					r0 = '{value: PIX_W'(run_class_q), len: run_count_q,
					       eof: 1'b0, rej: 1'b0};
					n  = 2'd1;
				end
				nx_class = q_data.cls;
				nx_count = RUN_ONE;
				nx_open  = 1'b1;
			end
			if (q_data.last) begin
				fl = '{value: PIX_W'(nx_class), len: nx_count, eof: 1'b1, rej: 1'b0};
				if (n == 2'd0) begin
					r0 = fl;
				end else begin
					r1 = fl;
				end
				n        = n + 2'd1;
				nx_open  = 1'b0;
				nx_class = '0;
				nx_count = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
			run_open_q   <= 1'b0;
			run_class_q  <= '0;
			run_count_q  <= '0;
		end else begin
			if (pend_valid_q && out_free) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (q_pop) begin
				out_valid_q  <= n != 2'd0;
				pend_valid_q <= n == 2'd2;
			end else if (take) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				run_open_q  <= nx_open;
				run_class_q <= nx_class;
				run_count_q <= nx_count;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_valid_q && out_free) begin
			out_q <= pend_q;
		end else if (q_pop) begin
			out_q  <= r0;
			pend_q <= r1;
		end
	end

	assign result_valid = out_valid_q;
	assign value        = out_q.value;
	assign run_length   = out_q.len;
	assign end_of_frame = out_q.eof;
	assign rejected     = out_q.rej;

	assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> out_valid_q)
		else $error("held result without a result in the output register");

	assert property (@(posedge clk) disable iff (!arst_n)
		run_open_q |-> run_count_q != '0)
		else $error("open run with zero count");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.rej) |-> (out_q.eof && out_q.len == '0))
		else $error("rejection result must close the frame with zero length");

endmodule

// File: rtl/mode_vote_downscale_rle.sv
// ----------------------------------------------------------------------------
// mode_vote_downscale_rle
// 2x2 mode-vote downscaler with raw or run-length coded output.
//
//   port group     dir  handshake                     payload
//   pixel          in   pixel_valid / pixel_stall     pixel
//   result         out  result_valid / result_stall   value, run_length,
//                                                     end_of_frame, rejected
//   cfg            in   cfg_we (no wait)              cfg_index, cfg_data
//
// One pixel per clock is taken while pixel_stall is low. A block's result
// passes RAM read, vote into the queue and result register before result_valid.
// A compressed frame end may yield two results; the second waits in the holding
// register, and the job queue absorbs the wait.
// Reset is asynchronous; the top row RAMs are not cleared.
// Input stalls only when the job queue is full and a job is waiting to enter it.
// ----------------------------------------------------------------------------
module mode_vote_downscale_rle #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pixel_valid,
	output logic                           pixel_stall,
	input  logic [mvd_pkg::PIX_W-1:0]      pixel,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [mvd_pkg::PIX_W-1:0]      value,
	output logic [mvd_pkg::RUN_W-1:0]      run_length,
	output logic                           end_of_frame,
	output logic                           rejected,
	input  logic                           cfg_we,
	input  logic [mvd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mvd_pkg::CFG_DATA_W-1:0] cfg_data
);

	import mvd_pkg::*;

	logic              compress_mode_q;
	logic [SIDE_W-1:0] image_width_q;
	logic [SIDE_W-1:0] image_height_q;
	logic [MIN_W-1:0]  min_side_q;

	logic     q_push, q_full, q_pop, q_empty;
	mvd_cmd_t q_wdata, q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compress_mode_q <= 1'b0;
			image_width_q   <= WIDTH_RST;
			image_height_q  <= HEIGHT_RST;
			min_side_q      <= MIN_SIDE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_COMPRESS: compress_mode_q <= cfg_data[0];
				CFG_WIDTH:    image_width_q   <= cfg_data;
				CFG_HEIGHT:   image_height_q  <= cfg_data;
				CFG_MIN_SIDE: min_side_q      <= cfg_data[MIN_W-1:0];
				default: ;
			endcase
		end
	end

	mvd_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel        (pixel),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.min_side     (min_side_q),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (q_wdata)
	);

	mvd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	mvd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.compress_mode (compress_mode_q),
		.q_empty       (q_empty),
		.q_data        (q_rdata),
		.q_pop         (q_pop),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.value         (value),
		.run_length    (run_length),
		.end_of_frame  (end_of_frame),
		.rejected      (rejected)
	);

endmodule
